/* hw/rtl/nih_pkg.sv */
// shared constants and types of the name intern hash table
package nih_pkg;

   localparam int NAME_CAPACITY = 256;
   localparam int BUCKET_MAX    = 256;

   localparam int NAME_W       = 32;
   localparam int ENTRY_IDX_W  = $clog2(NAME_CAPACITY + 1);
   localparam int ENTRY_ADDR_W = $clog2(NAME_CAPACITY);
   localparam int BUCKET_W     = $clog2(BUCKET_MAX);
   localparam int DIVISOR_W    = $clog2(BUCKET_MAX + 1);
   localparam int OFFSET_W     = 16;
   localparam int INDEX_OUT_W  = 17;
   localparam int CSR_COUNT_W  = 9;

   // modulo unit retires this many dividend bits per cycle
   localparam int MOD_DIGIT_W = 4;
   localparam int MOD_STEPS   = NAME_W / MOD_DIGIT_W;
   localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register select, taken from paddr bit 2
   localparam logic CSR_BUCKET_COUNT  = 1'b0;
   localparam logic CSR_SYSTEM_OFFSET = 1'b1;

   localparam logic [DIVISOR_W-1:0] BUCKET_COUNT_RESET = DIVISOR_W'(251);

   typedef struct packed {
      logic [ENTRY_IDX_W-1:0] link;
      logic [NAME_W-1:0]      name;
   } nih_entry_type;

   typedef struct packed {
      logic                   status;
      logic [ENTRY_IDX_W-1:0] entry;
   } nih_result_type;

endpackage

/* hw/rtl/nih_mod_unit.sv */
// iterative remainder of a name magnitude by the bucket count, four bits per cycle
module nih_mod_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [nih_pkg::NAME_W-1:0]    name_word,
   input  logic [nih_pkg::DIVISOR_W-1:0] divisor,
   output logic                          done,
   output logic [nih_pkg::BUCKET_W-1:0]  remainder
);
   import nih_pkg::*;

   localparam int REM_W = BUCKET_W + 1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] count_ff, count_in;
   logic [NAME_W-1:0]    dividend_ff, dividend_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [BUCKET_W-1:0]  rem_ff, rem_in;
   logic [NAME_W-1:0]    magnitude;
   logic [BUCKET_W-1:0]  rem_step;

   // most negative name saturates to the largest positive value
   always_comb begin
      if (!name_word[NAME_W-1]) begin
         magnitude = name_word;
      end else if (name_word[NAME_W-2:0] == '0) begin
         magnitude = {1'b0, {(NAME_W-1){1'b1}}};
      end else begin
         magnitude = ~name_word + 1'b1;
      end
   end

   // restoring steps over the top digit of the dividend
   always_comb begin
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] div_ext;
      div_ext = REM_W'(divisor_ff);
      rem_step = rem_ff;
      for (int i = 0; i < MOD_DIGIT_W; i++) begin
         trial = {rem_step, dividend_ff[NAME_W-1-i]};
         if (trial >= div_ext) begin
            trial = trial - div_ext;
         end
         rem_step = trial[BUCKET_W-1:0];
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (start) begin
         busy_in     = 1'b1;
         count_in    = '0;
         dividend_in = magnitude;
         divisor_in  = divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         rem_in      = rem_step;
         dividend_in = dividend_ff << MOD_DIGIT_W;
         count_in    = count_ff + 1'b1;
         if (count_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/nih_walker.sv */
// bucket head and entry memories with the chain walk and append sequencer
module nih_walker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [nih_pkg::NAME_W-1:0]    req_name,
   input  logic [nih_pkg::DIVISOR_W-1:0] divisor,
   output logic                          res_valid,
   input  logic                          res_ready,
   output nih_pkg::nih_result_type       res
);
   import nih_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_HEAD_RD,
      ST_HEAD_CHK,
      ST_ENT_CHK,
      ST_MISS,
      ST_LINK,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [NAME_W-1:0]      name_ff, name_in;
   logic [BUCKET_W-1:0]    bucket_ff, bucket_in;
   logic [ENTRY_IDX_W-1:0] cur_ff, cur_in;
   logic [ENTRY_IDX_W-1:0] tail_ff, tail_in;
   logic [NAME_W-1:0]      tail_name_ff, tail_name_in;
   logic [ENTRY_IDX_W-1:0] found_ff, found_in;
   logic                   status_ff, status_in;
   logic [ENTRY_IDX_W-1:0] names_used_ff, names_used_in;

   logic                   mod_start;
   logic                   mod_done;
   logic [BUCKET_W-1:0]    mod_rem;

   // bucket heads: valid bits stand in for the all-empty reset
   logic [ENTRY_IDX_W-1:0] head_mem [BUCKET_MAX];
   logic [BUCKET_MAX-1:0]  head_vld_ff;
   logic [ENTRY_IDX_W-1:0] head_rd_ff;
   logic                   head_vld_rd_ff;
   logic                   head_rd_en;
   logic                   head_wr_en;
   logic [ENTRY_IDX_W-1:0] head_wr_data;
   logic [ENTRY_IDX_W-1:0] head_val;

   // entries hold name and link side by side, address is index minus one
   nih_entry_type          ent_mem [NAME_CAPACITY];
   nih_entry_type          ent_rd_ff;
   logic                   ent_rd_en;
   logic [ENTRY_ADDR_W-1:0] ent_rd_addr;
   logic                   ent_wr_en;
   logic [ENTRY_ADDR_W-1:0] ent_wr_addr;
   nih_entry_type          ent_wr_data;
   logic [ENTRY_IDX_W-1:0] new_idx;

   function automatic logic valid_entry(input logic [ENTRY_IDX_W-1:0] idx);
      return (idx != '0) && (idx <= ENTRY_IDX_W'(NAME_CAPACITY));
   endfunction

   nih_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .name_word (req_name),
      .divisor   (divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign head_val = head_vld_rd_ff ? head_rd_ff : '0;
   assign new_idx  = names_used_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      name_in       = name_ff;
      bucket_in     = bucket_ff;
      cur_in        = cur_ff;
      tail_in       = tail_ff;
      tail_name_in  = tail_name_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      names_used_in = names_used_ff;
      req_tready    = 1'b0;
      res_valid     = 1'b0;
      mod_start     = 1'b0;
      head_rd_en    = 1'b0;
      head_wr_en    = 1'b0;
      head_wr_data  = new_idx;
      ent_rd_en     = 1'b0;
      ent_rd_addr   = '0;
      ent_wr_en     = 1'b0;
      ent_wr_addr   = ENTRY_ADDR_W'(new_idx - 1'b1);
      ent_wr_data   = '{link: '0, name: name_ff};
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               name_in   = req_name;
               tail_in   = '0;
               mod_start = 1'b1;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               bucket_in = mod_rem;
               state_in  = ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: begin
            head_rd_en = 1'b1;
            state_in   = ST_HEAD_CHK;
         end
         ST_HEAD_CHK: begin
            if (valid_entry(head_val)) begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = ENTRY_ADDR_W'(head_val - 1'b1);
               cur_in      = head_val;
               state_in    = ST_ENT_CHK;
            end else begin
               state_in = ST_MISS;
            end
         end
         ST_ENT_CHK: begin
            if (ent_rd_ff.name == name_ff) begin
               found_in  = cur_ff;
               status_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               tail_in      = cur_ff;
               tail_name_in = ent_rd_ff.name;
               if (valid_entry(ent_rd_ff.link)) begin
                  ent_rd_en   = 1'b1;
                  ent_rd_addr = ENTRY_ADDR_W'(ent_rd_ff.link - 1'b1);
                  cur_in      = ent_rd_ff.link;
               end else begin
                  state_in = ST_MISS;
               end
            end
         end
         ST_MISS: begin
            if (names_used_ff == ENTRY_IDX_W'(NAME_CAPACITY)) begin
               found_in  = '0;
               status_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               found_in      = new_idx;
               status_in     = 1'b0;
               names_used_in = new_idx;
               ent_wr_en     = 1'b1;
               if (tail_ff == '0) begin
                  head_wr_en = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_LINK;
               end
            end
         end
         ST_LINK: begin
            // old tail now points at the entry just added
            ent_wr_en   = 1'b1;
            ent_wr_addr = ENTRY_ADDR_W'(tail_ff - 1'b1);
            ent_wr_data = '{link: found_ff, name: tail_name_ff};
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         names_used_ff <= '0;
      end else begin
         state_ff      <= state_in;
         names_used_ff <= names_used_in;
      end
      name_ff      <= name_in;
      bucket_ff    <= bucket_in;
      cur_ff       <= cur_in;
      tail_ff      <= tail_in;
      tail_name_ff <= tail_name_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
      end else if (head_wr_en) begin
         head_vld_ff[bucket_ff] <= 1'b1;
      end
   end

   // writes only land after the walk of the same item, so no forwarding path
   always_ff @(posedge clock) begin
      if (head_wr_en) begin
         head_mem[bucket_ff] <= head_wr_data;
      end
      if (head_rd_en) begin
         head_rd_ff     <= head_mem[bucket_ff];
         head_vld_rd_ff <= head_vld_ff[bucket_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ent_wr_en) begin
         ent_mem[ent_wr_addr] <= ent_wr_data;
      end
      if (ent_rd_en) begin
         ent_rd_ff <= ent_mem[ent_rd_addr];
      end
   end

   assign res = '{status: status_ff, entry: found_ff};

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      names_used_ff <= ENTRY_IDX_W'(NAME_CAPACITY))
      else $error("entry count beyond capacity");

   a_used_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_MISS) |=> $stable(names_used_ff))
      else $error("entry count moved outside an append");

   a_full_has_no_index: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status) |-> (res.entry == '0))
      else $error("full status with nonzero index");

   a_link_needs_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINK) |-> valid_entry(tail_ff) && valid_entry(found_ff))
      else $error("tail link update without a tail entry");

   a_ok_index_valid: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res.status) |-> valid_entry(res.entry))
      else $error("result index outside the table");

endmodule

/* hw/rtl/name_intern_hash_table.sv */
// top level: register port, walker and result output register
//
//  channel  dir   handshake                 payload
//  req      in    req_tvalid / req_tready   tdata[31:0] name_word
//  rsp      out   rsp_tvalid / rsp_tready   tdata[16:0] entry_index, tuser status
//  csr      in    psel / penable / pready   bucket_count at 0x0, system_offset at 0x4
//
// one item at a time: accept, modulo (8 steps of 4 bits, then the done flag), head read
// and check, one entry read per chain hop, one or two append writes on a miss,
// then handoff
// reset is synchronous; bucket heads are cleared through per-bucket valid bits
// in the same cycle, so no clearing pass is needed
// a result waiting on rsp back-pressure sits in the output register while the
// next item is already taken and walked
module name_intern_hash_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // [31:0] name_word
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // [16:0] entry_index, rest zero
   output logic                           rsp_tuser,   // [0] status
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [nih_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [nih_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nih_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import nih_pkg::*;

   logic [CSR_COUNT_W-1:0] bucket_count_ff, bucket_count_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic [DIVISOR_W-1:0]   divisor;
   logic                   csr_write;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic                   res_valid;
   logic                   res_ready;
   nih_result_type         res;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      bucket_count_in = bucket_count_ff;
      offset_in       = offset_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_BUCKET_COUNT:  bucket_count_in = csr_pwdata[CSR_COUNT_W-1:0];
            CSR_SYSTEM_OFFSET: offset_in       = csr_pwdata[OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_BUCKET_COUNT:  csr_prdata = CSR_DATA_W'(bucket_count_ff);
         CSR_SYSTEM_OFFSET: csr_prdata = CSR_DATA_W'(offset_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // zero counts as one bucket, large counts clip to the table size
   always_comb begin
      if (bucket_count_ff == '0) begin
         divisor = DIVISOR_W'(1);
      end else if (bucket_count_ff > CSR_COUNT_W'(BUCKET_MAX)) begin
         divisor = DIVISOR_W'(BUCKET_MAX);
      end else begin
         divisor = DIVISOR_W'(bucket_count_ff);
      end
   end

   nih_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_name   (req_tdata),
      .divisor    (divisor),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res.status;
         rsp_index_in  = res.status ? '0
                       : INDEX_OUT_W'(res.entry) + INDEX_OUT_W'(offset_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
         offset_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         bucket_count_ff <= bucket_count_in;
         offset_ff       <= offset_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24 - INDEX_OUT_W){1'b0}}, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
